// ===== hw/rtl/rpvg_pkg.sv =====
package rpvg_pkg;

    localparam int MAX_SIDES  = 64;
    localparam int MIN_SIDES  = 3;
    localparam int TABLE_BITS = 8;
    localparam int TBL_N      = 1 << TABLE_BITS;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [15:0] TOP_PHASE   = 16'd49152;
    localparam logic [15:0] QUARTER_TURN = 16'd16384;
    localparam logic [6:0]  SIDES_RESET = 7'd3;
    localparam logic [15:0] STEP_RESET  = 16'd21845;

    typedef logic [15:0] sine_table_t [0:TBL_N];
    typedef logic [15:0] step_table_t [0:127];

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic issue;
    } ctrl_cmd_t;

    typedef struct packed {
        logic last_issue;
        logic pipe_empty;
    } dp_status_t;

    // Divisors (2n)(2n+1) of the sine series, n = 1..10.
    localparam logic [63:0] SERIES_DIVISOR [1:10] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
        64'd156, 64'd210, 64'd272, 64'd342, 64'd420
    };

    // Restoring division, used only while the constant tables are built.
    function automatic logic [63:0] const_div(input logic [63:0] num,
                                              input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Quarter-wave sine in Q2.14, evaluated during elaboration.
    function automatic sine_table_t build_sine_table();
        sine_table_t         tbl;
        logic [63:0]         x;
        logic [63:0]         x2;
        logic [63:0]         term;
        logic signed [63:0]  sum;
        for (int k = 0; k <= TBL_N; k++) begin
            x    = (HALF_PI_Q30 * 64'(k)) >> TABLE_BITS;
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            for (int n = 1; n <= 10; n++) begin
                term = const_div((term * x2) >> 30, SERIES_DIVISOR[n]);
                if ((n & 1) == 1) begin
                    sum = sum - $signed(term);
                end
                else begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0) begin
                sum = '0;
            end
            tbl[k] = 16'(($unsigned(sum) + 64'd32768) >> 16);
        end
        return tbl;
    endfunction

    // Phase step round(65536 / sides) for every legal side count.
    function automatic step_table_t build_step_table();
        step_table_t tbl;
        for (int k = 0; k < 128; k++) begin
            if (k >= MIN_SIDES && k <= MAX_SIDES) begin
                tbl[k] = 16'(const_div(64'(65536 + (k >> 1)), 64'(k)));
            end
            else begin
                tbl[k] = '0;
            end
        end
        return tbl;
    endfunction

    localparam sine_table_t SINE_TABLE = build_sine_table();
    localparam step_table_t STEP_TABLE = build_step_table();

    function automatic logic signed [15:0] sine_of(input logic [15:0] phase);
        logic [TABLE_BITS-1:0] j;
        logic [TABLE_BITS:0]   idx;
        logic [15:0]           mag;
        j = phase[13 -: TABLE_BITS];
        if (phase[14]) begin
            idx = TBL_N[TABLE_BITS:0] - {1'b0, j};
        end
        else begin
            idx = {1'b0, j};
        end
        mag = SINE_TABLE[idx];
        if (phase[15]) begin
            return -$signed(mag);
        end
        return $signed(mag);
    endfunction

endpackage

// ===== hw/rtl/regular_polygon_vertex_generator.sv =====
// Regular polygon vertex generator.
// A rectangle is offered on left_edge, top_edge, right_edge and bottom_edge
// with start; it is taken at a clock edge where start is high and busy low.
// The block then emits side_count vertices of the regular polygon inscribed
// in the rectangle's ellipse, one beat per cycle on consecutive cycles, each
// marked by vertex_valid for a single cycle. The first vertex is at the top
// (vertex_index 0) and last_vertex marks the final one.
// Each vertex is issued into the sine table, multiplier and rounding stages,
// one per cycle, and busy stays high until those stages have drained, so the
// next rectangle is taken only after the last vertex of the previous one.
// side_count is written through cfg_write_en / cfg_write_data while busy is
// low; the user must keep to this, as the block does not enforce it. Values
// outside 3..64 are ignored.
// Reset sets side_count to 3 and clears the pipeline. The receiver cannot
// stall: every beat must be taken in the cycle it is shown.
module regular_polygon_vertex_generator
    import rpvg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [6:0]         cfg_write_data,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] left_edge,
    input  logic signed [15:0] top_edge,
    input  logic signed [15:0] right_edge,
    input  logic signed [15:0] bottom_edge,
    output logic               vertex_valid,
    output logic signed [16:0] vertex_x,
    output logic signed [16:0] vertex_y,
    output logic [5:0]         vertex_index,
    output logic               last_vertex
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    rpvg_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    rpvg_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .cmd            (cmd),
        .status         (status),
        .left_edge      (left_edge),
        .top_edge       (top_edge),
        .right_edge     (right_edge),
        .bottom_edge    (bottom_edge),
        .vertex_valid   (vertex_valid),
        .vertex_x       (vertex_x),
        .vertex_y       (vertex_y),
        .vertex_index   (vertex_index),
        .last_vertex    (last_vertex)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after a rectangle was taken");

    a_beat_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        vertex_valid |-> $past(busy))
        else $error("vertex beat without a rectangle in progress");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (vertex_valid && last_vertex) |=> !vertex_valid)
        else $error("vertex beat followed the last vertex");

    a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (vertex_valid && !last_vertex) |=>
            (vertex_valid && vertex_index == $past(vertex_index) + 6'd1))
        else $error("vertex beats not consecutive");

endmodule

// ===== hw/rtl/rpvg_ctrl.sv =====
module rpvg_ctrl
    import rpvg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd,
    output logic       busy
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (status.last_issue) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (status.pipe_empty) begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd.load  = 1'b0;
        cmd.issue = 1'b0;
        busy      = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_RUN:
            begin
                cmd.issue = 1'b1;
            end
            ST_DRAIN:
            begin
                busy = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/rpvg_datapath.sv =====
module rpvg_datapath
    import rpvg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [6:0]         cfg_write_data,
    input  ctrl_cmd_t          cmd,
    output dp_status_t         status,
    input  logic signed [15:0] left_edge,
    input  logic signed [15:0] top_edge,
    input  logic signed [15:0] right_edge,
    input  logic signed [15:0] bottom_edge,
    output logic               vertex_valid,
    output logic signed [16:0] vertex_x,
    output logic signed [16:0] vertex_y,
    output logic [5:0]         vertex_index,
    output logic               last_vertex
);

    logic [6:0]  side_count_reg;
    logic [15:0] phase_step_reg;
    logic [15:0] phase_reg;
    logic [5:0]  counter_reg;

    logic signed [16:0] center_x_reg;
    logic signed [16:0] center_y_reg;
    logic signed [16:0] radius_x_reg;
    logic signed [16:0] radius_y_reg;

    logic signed [16:0] sum_x;
    logic signed [16:0] sum_y;
    logic signed [16:0] diff_x;
    logic signed [16:0] diff_y;
    logic               issue_last;

    // Stage 1: trig values.
    logic               s1_valid_reg;
    logic signed [15:0] s1_sin_reg;
    logic signed [15:0] s1_cos_reg;
    logic [5:0]         s1_index_reg;
    logic               s1_last_reg;

    // Stage 2: products.
    logic               s2_valid_reg;
    logic signed [32:0] s2_prod_x_reg;
    logic signed [32:0] s2_prod_y_reg;
    logic [5:0]         s2_index_reg;
    logic               s2_last_reg;

    logic signed [33:0] acc_x;
    logic signed [33:0] acc_y;
    logic signed [16:0] coord_x;
    logic signed [16:0] coord_y;

    function automatic logic signed [16:0] half_to_zero(input logic signed [16:0] v);
        logic signed [16:0] t;
        t = v + {16'd0, v[16]};
        return t >>> 1;
    endfunction

    function automatic logic signed [16:0] q14_to_zero(input logic signed [33:0] v);
        logic signed [19:0] q;
        q = 20'(v >>> 14);
        if (v[33] && (v[13:0] != 14'd0)) begin
            q = q + 20'sd1;
        end
        return q[16:0];
    endfunction

    assign sum_x  = 17'(left_edge) + 17'(right_edge);
    assign sum_y  = 17'(top_edge) + 17'(bottom_edge);
    assign diff_x = 17'(right_edge) - 17'(left_edge);
    assign diff_y = 17'(bottom_edge) - 17'(top_edge);

    assign issue_last = ({1'b0, counter_reg} == (side_count_reg - 7'd1));

    assign status.last_issue = cmd.issue && issue_last;
    assign status.pipe_empty = !s1_valid_reg && !s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            side_count_reg <= SIDES_RESET;
            phase_step_reg <= STEP_RESET;
        end
        else if (cfg_write_en && cfg_write_data >= 7'(MIN_SIDES)
                 && cfg_write_data <= 7'(MAX_SIDES)) begin
            side_count_reg <= cfg_write_data;
            phase_step_reg <= STEP_TABLE[cfg_write_data];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg   <= '0;
            counter_reg <= '0;
        end
        else if (cmd.load) begin
            phase_reg   <= TOP_PHASE;
            counter_reg <= '0;
        end
        else if (cmd.issue) begin
            phase_reg   <= phase_reg + phase_step_reg;
            counter_reg <= counter_reg + 6'd1;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.load) begin
            center_x_reg <= half_to_zero(sum_x);
            center_y_reg <= half_to_zero(sum_y);
            radius_x_reg <= half_to_zero(diff_x);
            radius_y_reg <= half_to_zero(diff_y);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            vertex_valid <= 1'b0;
        end
        else begin
            s1_valid_reg <= cmd.issue;
            s2_valid_reg <= s1_valid_reg;
            vertex_valid <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        s1_sin_reg    <= sine_of(phase_reg);
        s1_cos_reg    <= sine_of(phase_reg + QUARTER_TURN);
        s1_index_reg  <= counter_reg;
        s1_last_reg   <= issue_last;

        s2_prod_x_reg <= 33'(radius_x_reg) * 33'(s1_cos_reg);
        s2_prod_y_reg <= 33'(radius_y_reg) * 33'(s1_sin_reg);
        s2_index_reg  <= s1_index_reg;
        s2_last_reg   <= s1_last_reg;

        vertex_x      <= coord_x;
        vertex_y      <= coord_y;
        vertex_index  <= s2_index_reg;
        last_vertex   <= s2_last_reg;
    end

    // Round half up in Q14, then truncate toward zero.
    assign acc_x = 34'(s2_prod_x_reg) + (34'(center_x_reg) <<< 14) + 34'sd8192;
    assign acc_y = 34'(s2_prod_y_reg) + (34'(center_y_reg) <<< 14) + 34'sd8192;
    assign coord_x = q14_to_zero(acc_x);
    assign coord_y = q14_to_zero(acc_y);

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import rpvg_pkg::*;

    typedef struct {
        logic signed [16:0] x;
        logic signed [16:0] y;
        logic [5:0]         index;
        logic               last;
    } vertex_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_write_en = 1'b0;
    logic [6:0]         cfg_write_data = '0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [15:0] left_edge = '0;
    logic signed [15:0] top_edge = '0;
    logic signed [15:0] right_edge = '0;
    logic signed [15:0] bottom_edge = '0;
    logic               vertex_valid;
    logic signed [16:0] vertex_x;
    logic signed [16:0] vertex_y;
    logic [5:0]         vertex_index;
    logic               last_vertex;

    vertex_t     pending_vertices[$];
    int          quarter_sine [0:TBL_N];
    int          sides_now = 3;
    logic [15:0] step_now = 16'd21845;
    int          mismatch_count = 0;
    bit          no_gaps = 1'b0;

    regular_polygon_vertex_generator dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .start          (start),
        .busy           (busy),
        .left_edge      (left_edge),
        .top_edge       (top_edge),
        .right_edge     (right_edge),
        .bottom_edge    (bottom_edge),
        .vertex_valid   (vertex_valid),
        .vertex_x       (vertex_x),
        .vertex_y       (vertex_y),
        .vertex_index   (vertex_index),
        .last_vertex    (last_vertex)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("tb: errors");
        $finish;
    end

    function automatic int sine_q14(logic [15:0] phase);
        int j;
        int mag;
        j = int'(phase[13:0]) >> (14 - TABLE_BITS);
        mag = phase[14] ? quarter_sine[TBL_N - j] : quarter_sine[j];
        return phase[15] ? -mag : mag;
    endfunction

    function automatic logic signed [16:0] place_coord(int radius, int trig, int centre);
        longint acc;
        acc = longint'(radius) * trig + longint'(centre) * 16384 + 8192;
        acc = acc / 16384;
        return acc[16:0];
    endfunction

    // Every vertex of the polygon is queued at the edge where the rectangle is taken.
    task automatic predict_polygon(logic signed [15:0] l, logic signed [15:0] t,
                                   logic signed [15:0] r, logic signed [15:0] b);
        int          cx;
        int          cy;
        int          rx;
        int          ry;
        logic [15:0] phase;
        vertex_t     v;
        cx = (int'(l) + int'(r)) / 2;
        cy = (int'(t) + int'(b)) / 2;
        rx = (int'(r) - int'(l)) / 2;
        ry = (int'(b) - int'(t)) / 2;
        phase = TOP_PHASE;
        for (int i = 0; i < sides_now; i++)
        begin
            v.x = place_coord(rx, sine_q14(phase + QUARTER_TURN), cx);
            v.y = place_coord(ry, sine_q14(phase), cy);
            v.index = 6'(i);
            v.last = (i == sides_now - 1);
            pending_vertices.push_back(v);
            phase = phase + step_now;
        end
    endtask

    // Called at a rising edge; returns at the edge where the rectangle is taken.
    task automatic send_rect(logic signed [15:0] l, logic signed [15:0] t,
                             logic signed [15:0] r, logic signed [15:0] b);
        start <= 1'b1;
        left_edge <= l;
        top_edge <= t;
        right_edge <= r;
        bottom_edge <= b;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        predict_polygon(l, t, r, b);
    endtask

    task automatic maybe_gap();
        if (!no_gaps && $urandom_range(0, 99) < 22)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, sides_now + 8)) @(posedge clk);
        end
    endtask

    task automatic drain_block();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_vertices.size() != 0 || busy);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_sides(logic [6:0] value);
        drain_block();
        cfg_write_en <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        if (value >= MIN_SIDES && value <= MAX_SIDES)
        begin
            sides_now = value;
            step_now = 16'((65536 + sides_now / 2) / sides_now);
        end
        @(posedge clk);
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        vertex_t want;
        if (rst_n && vertex_valid)
        begin
            if (pending_vertices.size() == 0)
            begin
                $display("%0t: unexpected vertex expected none got x %0d y %0d index %0d",
                         $time, vertex_x, vertex_y, vertex_index);
                mismatch_count++;
            end
            else
            begin
                want = pending_vertices.pop_front();
                check_field("vertex_x", want.x, vertex_x);
                check_field("vertex_y", want.y, vertex_y);
                check_field("vertex_index", want.index, vertex_index);
                check_field("last_vertex", want.last, last_vertex);
            end
        end
    end

    // The reset side count of three, before any register write.
    task automatic test_reset_sides();
        send_rect(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
        send_rect(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        maybe_gap();
        send_rect(16'sd100, -16'sd50, 16'sd300, 16'sd250);
    endtask

    // Field extremes, reversed rectangles and halving of odd negative sums.
    task automatic test_extremes();
        write_sides(7'd4);
        send_rect(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
        send_rect(16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768);
        maybe_gap();
        send_rect(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
        send_rect(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
        send_rect(-16'sd3, -16'sd5, 16'sd0, 16'sd0);
        send_rect(-16'sd1, -16'sd1, 16'sd0, 16'sd0);
        maybe_gap();
        send_rect(16'sd10, 16'sd27, 16'sd13, 16'sd20);
        send_rect(-16'sd1, 16'sd32767, -16'sd32768, -16'sd1);
    endtask

    // Side count limits; writes outside the legal range must leave it unchanged.
    task automatic test_side_limits();
        write_sides(7'd64);
        send_rect(-16'sd20000, -16'sd15000, 16'sd20001, 16'sd15001);
        send_rect(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768);
        write_sides(7'd3);
        send_rect(-16'sd7, -16'sd9, 16'sd8, 16'sd11);
        write_sides(7'd2);
        write_sides(7'd0);
        write_sides(7'd65);
        write_sides(7'd127);
        write_sides(7'd100);
        write_sides(7'd1);
        send_rect(16'sd1000, 16'sd2000, 16'sd3000, 16'sd4000);
        write_sides(7'd5);
        send_rect(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
    endtask

    task automatic test_random(int count);
        int          next_write;
        int          mode;
        int          a;
        int          c;
        logic [15:0] l;
        logic [15:0] t;
        logic [15:0] r;
        logic [15:0] b;
        logic [15:0] swap;
        next_write = 0;
        for (int n = 0; n < count; n++)
        begin
            // The stretch without gaps also holds back register writes and their drain.
            no_gaps = (n >= 120 && n < 220);
            if (n >= next_write && !no_gaps)
            begin
                mode = $urandom_range(0, 19);
                if (mode == 0)
                    write_sides(7'd64);
                else if (mode == 1)
                    write_sides(7'($urandom_range(0, 127)));
                else
                    write_sides(7'($urandom_range(3, 12)));
                next_write = n + $urandom_range(25, 50);
            end
            if (n == 300)
                drain_block();
            mode = $urandom_range(0, 9);
            if (mode < 3)
            begin
                l = 16'($urandom);
                t = 16'($urandom);
                r = 16'($urandom);
                b = 16'($urandom);
            end
            else
            begin
                a = $urandom_range(0, 60000) - 32768;
                c = $urandom_range(0, 60000) - 32768;
                l = 16'(a);
                r = 16'(a + $urandom_range(0, 32767 - a));
                t = 16'(c);
                b = 16'(c + $urandom_range(0, 32767 - c));
                if (mode == 9)
                begin
                    swap = l;
                    l = r;
                    r = swap;
                end
            end
            send_rect(l, t, r, b);
            maybe_gap();
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        for (int k = 0; k <= TBL_N; k++)
        begin
            x = (64'd1686629713 * longint'(k)) >> TABLE_BITS;
            x2 = (x * x) >> 30;
            term = x;
            sum = longint'(x);
            for (int n = 1; n <= 10; n++)
            begin
                term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            quarter_sine[k] = int'((longint'(sum) + 32768) >>> 16);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reset_sides();
        test_extremes();
        test_side_limits();
        test_random(410);

        start <= 1'b0;
        while (pending_vertices.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_vertices.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
